FILE: rtl/tlshfc_pkg.sv
// shared constants, verdict codes and result type for the tls hostname frame classifier
package tlshfc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 1024;

    localparam logic [15:0] ETH_IPV4   = 16'h0800;
    localparam logic [15:0] ETH_IPV6   = 16'h86dd;
    localparam logic [6:0]  ETH_HDR    = 7'd14;
    localparam logic [5:0]  IPV6_HDR   = 6'd40;
    localparam logic [5:0]  MIN_HDR    = 6'd20;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  TLS_HS     = 8'h16;
    localparam logic [7:0]  HELLO      = 8'h01;
    localparam logic [63:0] WORD_LONG  = 64'h66616365626F6F6B;
    localparam logic [39:0] WORD_SHORT = 40'h666263646E;

    localparam logic [15:0] TARGET_PORT_RST = 16'd443;
    localparam logic [9:0]  SCAN_START_RST  = 10'd46;

    localparam logic [1:0] CFG_TARGET_PORT = 2'd0;
    localparam logic [1:0] CFG_SCAN_START  = 2'd1;

    localparam logic [3:0] VERDICT_MATCH      = 4'd0;
    localparam logic [3:0] VERDICT_NOT_IP     = 4'd1;
    localparam logic [3:0] VERDICT_BAD_IP     = 4'd2;
    localparam logic [3:0] VERDICT_NOT_TCP    = 4'd3;
    localparam logic [3:0] VERDICT_BAD_TCP    = 4'd4;
    localparam logic [3:0] VERDICT_OTHER_PORT = 4'd5;
    localparam logic [3:0] VERDICT_NOT_HELLO  = 4'd6;
    localparam logic [3:0] VERDICT_NO_KEYWORD = 4'd7;
    localparam logic [3:0] VERDICT_TRUNCATED  = 4'd8;

    localparam logic [1:0] IPVER_NONE = 2'd0;
    localparam logic [1:0] IPVER_V4   = 2'd1;
    localparam logic [1:0] IPVER_V6   = 2'd2;

    typedef struct packed {
        logic [31:0] dest_ipv4;
        logic [31:0] source_ipv4;
        logic [15:0] source_port;
        logic [1:0]  ip_version;
        logic [3:0]  verdict;
        logic        detected;
    } result_t;

endpackage

FILE: rtl/tls_hostname_frame_classifier.sv
// top level of the tls hostname frame classifier: input stage, result register, config
// Takes one frame byte per clock on the slave stream, with tlast on the final byte, and
// returns one verdict transfer per frame on the master stream. A byte passes an input
// register, then one pass of the parser updates the frame state; on the last byte the
// verdict is written to the result register when that byte leaves the input register,
// and is held there until the master stream takes it.
// Throughput is one byte per cycle while the input is not stalled; input stalls
// only when a frame-end byte is waiting and the previous verdict has not been taken.
// The user is to write configuration only while no frame is in progress; the block does not enforce it.
module tls_hostname_frame_classifier #(
    parameter int MAX_FRAME_BYTES = tlshfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // frame_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // detected, verdict, ip_version, source_port,
                                        // source_ipv4, dest_ipv4, zero pad
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic                stage_valid_reg;
    logic [7:0]          stage_byte_reg;
    logic                stage_last_reg;
    logic                out_valid_reg;
    tlshfc_pkg::result_t out_result_reg;
    tlshfc_pkg::result_t result;
    logic [15:0]         target_port_reg;
    logic [9:0]          scan_start_reg;
    logic                out_free;
    logic                go;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign go            = stage_valid_reg && (!stage_last_reg || out_free);
    assign s_axis_tready = !stage_valid_reg || go;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_port_reg <= tlshfc_pkg::TARGET_PORT_RST;
            scan_start_reg  <= tlshfc_pkg::SCAN_START_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tlshfc_pkg::CFG_TARGET_PORT: target_port_reg <= cfg_wdata;
                tlshfc_pkg::CFG_SCAN_START:  scan_start_reg  <= cfg_wdata[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (s_axis_tready)
            stage_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            stage_byte_reg <= s_axis_tdata;
            stage_last_reg <= s_axis_tlast;
        end
    end

    tlshfc_frame_parser #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (go),
        .frame_byte (stage_byte_reg),
        .frame_end  (stage_last_reg),
        .target_port(target_port_reg),
        .scan_start (scan_start_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (go && stage_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (go && stage_last_reg)
            out_result_reg <= result;
    end

    a_detect_matches_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_result_reg.detected
                           == (out_result_reg.verdict == tlshfc_pkg::VERDICT_MATCH)))
        else $error("detected flag disagrees with verdict");

    a_no_addr_without_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (out_result_reg.ip_version != tlshfc_pkg::IPVER_V4))
        |-> (out_result_reg.source_ipv4 == 32'd0 && out_result_reg.dest_ipv4 == 32'd0))
        else $error("ipv4 address reported for a non-ipv4 frame");

    a_stall_only_on_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (stage_valid_reg && stage_last_reg && out_valid_reg
                            && !m_axis_tready))
        else $error("input stalled without a blocked verdict");

    a_verdict_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        (go && stage_last_reg) |=> m_axis_tvalid)
        else $error("frame end transfer produced no verdict");

endmodule

FILE: rtl/tlshfc_frame_parser.sv
// per-frame parse state, byte update and end-of-frame verdict logic
module tlshfc_frame_parser #(
    parameter int MAX_FRAME_BYTES = tlshfc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          frame_byte,
    input  logic                frame_end,
    input  logic [15:0]         target_port,
    input  logic [9:0]          scan_start,
    output tlshfc_pkg::result_t result
);

    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (OFF_W > 11) ? OFF_W : 11;

    logic [OFF_W-1:0] byte_offset_reg, byte_offset_next;
    logic [15:0]      ether_kind_reg, ether_kind_next;
    logic [5:0]       ip_header_bytes_reg, ip_header_bytes_next;
    logic [7:0]       payload_offset_reg, payload_offset_next;
    logic [63:0]      recent_bytes_reg, recent_bytes_next;
    logic             found_reg, found_next;
    logic             pending_reg, pending_next;
    logic [63:0]      addr_fields_reg, addr_fields_next;
    logic [63:0]      port_fields_reg, port_fields_next;

    always_comb
    begin
        logic [CMP_W-1:0] kw;
        logic [6:0]       tb;
        logic [CMP_W-1:0] tbw;
        logic [5:0]       th;
        logic [CMP_W-1:0] p;
        logic [CMP_W-1:0] scan_w;
        logic [CMP_W-1:0] pow;

        byte_offset_next     = byte_offset_reg;
        ether_kind_next      = ether_kind_reg;
        ip_header_bytes_next = ip_header_bytes_reg;
        payload_offset_next  = payload_offset_reg;
        recent_bytes_next    = recent_bytes_reg;
        found_next           = found_reg;
        pending_next         = pending_reg;
        addr_fields_next     = addr_fields_reg;
        port_fields_next     = port_fields_reg;
        kw     = CMP_W'(byte_offset_reg);
        scan_w = CMP_W'(scan_start);
        tb     = '0;
        tbw    = '0;
        th     = '0;
        p      = '0;
        pow    = '0;

        if (fire && (kw < CMP_W'(MAX_FRAME_BYTES)))
        begin
            recent_bytes_next = {recent_bytes_reg[55:0], frame_byte};
            if (kw == CMP_W'(12))
                ether_kind_next = {frame_byte, 8'h00};
            if (kw == CMP_W'(13))
            begin
                ether_kind_next = ether_kind_next | {8'h00, frame_byte};
                if (ether_kind_next == tlshfc_pkg::ETH_IPV6)
                    ip_header_bytes_next = tlshfc_pkg::IPV6_HDR;
            end
            if (ether_kind_next == tlshfc_pkg::ETH_IPV4)
            begin
                if (kw == CMP_W'(14))
                    ip_header_bytes_next = {frame_byte[3:0], 2'b00};
                if (kw == CMP_W'(23))
                    port_fields_next[31:24] = frame_byte;
                if ((kw >= CMP_W'(26)) && (kw <= CMP_W'(33)))
                    addr_fields_next[{3'(CMP_W'(33) - kw), 3'b000} +: 8] = frame_byte;
            end
            if ((ether_kind_next == tlshfc_pkg::ETH_IPV6) && (kw == CMP_W'(20)))
                port_fields_next[31:24] = frame_byte;

            if (ip_header_bytes_next >= tlshfc_pkg::MIN_HDR)
            begin
                tb  = tlshfc_pkg::ETH_HDR + {1'b0, ip_header_bytes_next};
                tbw = CMP_W'(tb);
                if (kw == tbw)
                    port_fields_next[63:56] = frame_byte;
                if (kw == tbw + CMP_W'(1))
                    port_fields_next[55:48] = frame_byte;
                if (kw == tbw + CMP_W'(2))
                    port_fields_next[47:40] = frame_byte;
                if (kw == tbw + CMP_W'(3))
                    port_fields_next[39:32] = frame_byte;
                if (kw == tbw + CMP_W'(12))
                begin
                    port_fields_next[23:16] = frame_byte;
                    th = {frame_byte[7:4], 2'b00};
                    if (th >= tlshfc_pkg::MIN_HDR)
                        payload_offset_next = {1'b0, tb} + {2'b00, th};
                end
            end

            pow = CMP_W'(payload_offset_next);
            if ((payload_offset_next != 8'd0) && (kw >= pow))
            begin
                p = kw - pow;
                if (p == CMP_W'(0))
                    port_fields_next[15:8] = frame_byte;
                if (p == CMP_W'(5))
                    port_fields_next[7:0] = frame_byte;
                if (pending_reg)
                    found_next = 1'b1;
                pending_next = 1'b0;
                if ((p >= scan_w + CMP_W'(7)) && (recent_bytes_next == tlshfc_pkg::WORD_LONG))
                    found_next = 1'b1;
                if ((p >= scan_w + CMP_W'(4))
                    && (recent_bytes_next[39:0] == tlshfc_pkg::WORD_SHORT))
                    pending_next = 1'b1;
            end
            byte_offset_next = byte_offset_reg + OFF_W'(1);
        end
    end

    // verdict on the state as it stands after the last byte
    always_comb
    begin
        logic [CMP_W-1:0] n;
        logic [CMP_W-1:0] tbw;
        logic [CMP_W-1:0] pow;
        logic [5:0]       th;
        logic [3:0]       verdict;
        logic [1:0]       ipver;

        n       = CMP_W'(byte_offset_next);
        tbw     = CMP_W'(tlshfc_pkg::ETH_HDR) + CMP_W'(ip_header_bytes_next);
        pow     = CMP_W'(payload_offset_next);
        th      = {port_fields_next[23:20], 2'b00};
        ipver   = tlshfc_pkg::IPVER_NONE;
        verdict = tlshfc_pkg::VERDICT_MATCH;

        if (n < CMP_W'(14))
            verdict = tlshfc_pkg::VERDICT_TRUNCATED;
        else
        begin
            if (ether_kind_next == tlshfc_pkg::ETH_IPV4)
            begin
                ipver = tlshfc_pkg::IPVER_V4;
                if (n < CMP_W'(15))
                    verdict = tlshfc_pkg::VERDICT_TRUNCATED;
                else if (ip_header_bytes_next < tlshfc_pkg::MIN_HDR)
                    verdict = tlshfc_pkg::VERDICT_BAD_IP;
                else if (n < CMP_W'(24))
                    verdict = tlshfc_pkg::VERDICT_TRUNCATED;
            end
            else if (ether_kind_next == tlshfc_pkg::ETH_IPV6)
            begin
                ipver = tlshfc_pkg::IPVER_V6;
                if (n < CMP_W'(21))
                    verdict = tlshfc_pkg::VERDICT_TRUNCATED;
            end
            else
                verdict = tlshfc_pkg::VERDICT_NOT_IP;

            if (verdict == tlshfc_pkg::VERDICT_MATCH)
            begin
                if (port_fields_next[31:24] != tlshfc_pkg::PROTO_TCP)
                    verdict = tlshfc_pkg::VERDICT_NOT_TCP;
                else if (n < tbw + CMP_W'(13))
                    verdict = tlshfc_pkg::VERDICT_TRUNCATED;
                else if (th < tlshfc_pkg::MIN_HDR)
                    verdict = tlshfc_pkg::VERDICT_BAD_TCP;
                else if (port_fields_next[47:32] != target_port)
                    verdict = tlshfc_pkg::VERDICT_OTHER_PORT;
                else if (n <= pow)
                    verdict = tlshfc_pkg::VERDICT_NOT_HELLO;
                else if (port_fields_next[15:8] != tlshfc_pkg::TLS_HS)
                    verdict = tlshfc_pkg::VERDICT_NOT_HELLO;
                else if ((n - pow) < CMP_W'(6))
                    verdict = tlshfc_pkg::VERDICT_TRUNCATED;
                else if (port_fields_next[7:0] != tlshfc_pkg::HELLO)
                    verdict = tlshfc_pkg::VERDICT_NOT_HELLO;
                else if (!found_next)
                    verdict = tlshfc_pkg::VERDICT_NO_KEYWORD;
            end
        end

        result.detected    = (verdict == tlshfc_pkg::VERDICT_MATCH);
        result.verdict     = verdict;
        result.ip_version  = ipver;
        result.source_port = port_fields_next[63:48];
        result.source_ipv4 = addr_fields_next[63:32];
        result.dest_ipv4   = addr_fields_next[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg     <= '0;
            ether_kind_reg      <= '0;
            ip_header_bytes_reg <= '0;
            payload_offset_reg  <= '0;
            recent_bytes_reg    <= '0;
            found_reg           <= 1'b0;
            pending_reg         <= 1'b0;
            addr_fields_reg     <= '0;
            port_fields_reg     <= '0;
        end
        else if (fire)
        begin
            if (frame_end)
            begin
                byte_offset_reg     <= '0;
                ether_kind_reg      <= '0;
                ip_header_bytes_reg <= '0;
                payload_offset_reg  <= '0;
                recent_bytes_reg    <= '0;
                found_reg           <= 1'b0;
                pending_reg         <= 1'b0;
                addr_fields_reg     <= '0;
                port_fields_reg     <= '0;
            end
            else
            begin
                byte_offset_reg     <= byte_offset_next;
                ether_kind_reg      <= ether_kind_next;
                ip_header_bytes_reg <= ip_header_bytes_next;
                payload_offset_reg  <= payload_offset_next;
                recent_bytes_reg    <= recent_bytes_next;
                found_reg           <= found_next;
                pending_reg         <= pending_next;
                addr_fields_reg     <= addr_fields_next;
                port_fields_reg     <= port_fields_next;
            end
        end
    end

endmodule
